FILE: rtl/core/bmhq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; used by binary_max_heap_queue_core.

package bmhq_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_BITS = 16;
	localparam int TAG_BITS = 16;

	localparam int ADDR_W  = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = KEY_BITS + TAG_BITS;
	localparam int OCC_W   = 8;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = KEY_BITS + TAG_BITS;
	localparam int OUT_DATA_W = KEY_BITS + TAG_BITS + OCC_W;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_ADDR,
		S_UP_CMP,
		S_RM_ROOT,
		S_RM_LAST,
		S_RM_HOLD,
		S_DN_ADDR,
		S_DN_LEFT,
		S_DN_CMP,
		S_FIN
	} state_t;

endpackage

FILE: rtl/core/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/binary_max_heap_queue_core.sv
// Binary max-heap priority queue: heap array in bmhq_ram, sifted by a small sequencer.
// Depends on bmhq_pkg and bmhq_ram.
//
//   channel   dir  tdata                                  tuser
//   s_axis    in   [15:0] priority_req, [31:16] tag       [0] mode
//   m_axis    out  [15:0] out_priority, [31:16] out_tag,  [1:0] status
//                  [39:32] occupancy
//
// One operation at a time; s_axis_tready is high only in idle, which the core enters
// after the result load, so the next input transfer comes after that load.
// Insert: per parent compared, a parent read then a compare/write, then the result
// load; an entry that climbs to the root is written there before the load.
// Remove: setup states for the root read, the last-entry read and a hold, then per
// node compared two child reads through the single RAM read port and a compare/write,
// then the result load; an entry that ends at a leaf is written there first.
// Refused operations go straight to the result load.
// A stalled output holds the core in its result-load state.
// Reset empties the heap at once; RAM contents are never read before written.
// A result waits in the output register; the core returns to idle once it is loaded.

module binary_max_heap_queue_core (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [bmhq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // priority_req, tag
	input  logic                            s_axis_tuser,  // mode

	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bmhq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_priority, out_tag, occupancy
	output logic [bmhq_pkg::STAT_W-1:0]     m_axis_tuser   // status
);

	localparam int AW = bmhq_pkg::ADDR_W;
	localparam int CW = bmhq_pkg::CNT_W;
	localparam int XW = bmhq_pkg::ADDR_W + 2;

	bmhq_pkg::state_t state_q, state_d;

	logic [CW-1:0]            count_q;
	logic [AW-1:0]            pos_q;
	bmhq_pkg::entry_t         e_q;
	bmhq_pkg::entry_t         c_q;
	logic [bmhq_pkg::STAT_W-1:0]   res_status_q;
	logic [bmhq_pkg::KEY_BITS-1:0] res_key_q;
	logic [bmhq_pkg::TAG_BITS-1:0] res_tag_q;

	logic                          out_valid_q;
	logic [bmhq_pkg::STAT_W-1:0]   out_status_q;
	logic [bmhq_pkg::KEY_BITS-1:0] out_key_q;
	logic [bmhq_pkg::TAG_BITS-1:0] out_tag_q;
	logic [bmhq_pkg::OCC_W-1:0]    out_occ_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	bmhq_pkg::entry_t         ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata;
	bmhq_pkg::entry_t         rd;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          out_load;
	logic [AW-1:0] parent_idx;
	logic [XW-1:0] lc_idx;
	logic [XW-1:0] rc_idx;
	logic [XW-1:0] count_x;
	logic          lc_out;
	logic          rc_in;
	logic          up_gt;
	logic          left_gt;
	logic          right_gt;
	logic [bmhq_pkg::KEY_BITS-1:0] best_key;

	bmhq_ram #(
		.WIDTH (bmhq_pkg::ENTRY_W),
		.DEPTH (bmhq_pkg::CAPACITY)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd = bmhq_pkg::entry_t'(ram_rdata);

	assign s_axis_tready = (state_q == bmhq_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_full       = (count_q >= CW'(bmhq_pkg::CAPACITY));
	assign is_empty      = (count_q == '0);
	assign out_load      = (state_q == bmhq_pkg::S_FIN) && (!out_valid_q || m_axis_tready);

	// index arithmetic: parent = (pos-1)/2, children = 2*pos+1, 2*pos+2
	assign parent_idx = (pos_q - AW'(1)) >> 1;
	assign lc_idx     = {1'b0, pos_q, 1'b1};
	assign rc_idx     = {1'b0, pos_q, 1'b0} + XW'(2);
	assign count_x    = XW'(count_q);
	assign lc_out     = (lc_idx >= count_x);
	assign rc_in      = (rc_idx < count_x);

	// shared comparator path; left child wins ties
	assign up_gt    = (e_q.key > rd.key);
	assign left_gt  = (c_q.key > e_q.key);
	assign best_key = left_gt ? c_q.key : e_q.key;
	assign right_gt = rc_in && (rd.key > best_key);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == bmhq_pkg::MODE_INSERT) begin
						state_d = is_full ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_ADDR;
					end else begin
						state_d = is_empty ? bmhq_pkg::S_FIN : bmhq_pkg::S_RM_ROOT;
					end
				end
			end
			bmhq_pkg::S_UP_ADDR: begin
				state_d = (pos_q == '0) ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_CMP;
			end
			bmhq_pkg::S_UP_CMP: begin
				state_d = up_gt ? bmhq_pkg::S_UP_ADDR : bmhq_pkg::S_FIN;
			end
			bmhq_pkg::S_RM_ROOT: state_d = bmhq_pkg::S_RM_LAST;
			bmhq_pkg::S_RM_LAST: state_d = bmhq_pkg::S_RM_HOLD;
			bmhq_pkg::S_RM_HOLD: state_d = bmhq_pkg::S_DN_ADDR;
			bmhq_pkg::S_DN_ADDR: begin
				state_d = lc_out ? bmhq_pkg::S_FIN : bmhq_pkg::S_DN_LEFT;
			end
			bmhq_pkg::S_DN_LEFT: state_d = bmhq_pkg::S_DN_CMP;
			bmhq_pkg::S_DN_CMP: begin
				state_d = (left_gt || right_gt) ? bmhq_pkg::S_DN_ADDR : bmhq_pkg::S_FIN;
			end
			bmhq_pkg::S_FIN: begin
				if (out_load) begin
					state_d = bmhq_pkg::S_IDLE;
				end
			end
			default: state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	// RAM control; the moving entry stays in e_q and is written once at its final slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = e_q;
		ram_raddr = '0;
		case (state_q)
			bmhq_pkg::S_UP_ADDR: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent_idx;
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = up_gt ? rd : e_q;
			end
			bmhq_pkg::S_RM_LAST: begin
				ram_raddr = count_q[AW-1:0];
			end
			bmhq_pkg::S_DN_ADDR: begin
				if (lc_out) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = lc_idx[AW-1:0];
				end
			end
			bmhq_pkg::S_DN_LEFT: begin
				ram_raddr = rc_idx[AW-1:0];
			end
			bmhq_pkg::S_DN_CMP: begin
				ram_we = 1'b1;
				if (right_gt) begin
					ram_wdata = rd;
				end else if (left_gt) begin
					ram_wdata = c_q;
				end else begin
					ram_wdata = e_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmhq_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (s_axis_tuser == bmhq_pkg::MODE_INSERT) begin
					if (!is_full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (!is_empty) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (accept) begin
					e_q.key   <= s_axis_tdata[bmhq_pkg::KEY_BITS-1:0];
					e_q.tag   <= s_axis_tdata[bmhq_pkg::IN_DATA_W-1:bmhq_pkg::KEY_BITS];
					pos_q     <= count_q[AW-1:0];
					res_key_q <= '0;
					res_tag_q <= '0;
					if (s_axis_tuser == bmhq_pkg::MODE_INSERT && is_full) begin
						res_status_q <= bmhq_pkg::STAT_FULL;
					end else if (s_axis_tuser == bmhq_pkg::MODE_REMOVE && is_empty) begin
						res_status_q <= bmhq_pkg::STAT_EMPTY;
					end else begin
						res_status_q <= bmhq_pkg::STAT_DONE;
					end
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				if (up_gt) begin
					pos_q <= parent_idx;
				end
			end
			bmhq_pkg::S_RM_LAST: begin
				res_key_q <= rd.key;
				res_tag_q <= rd.tag;
			end
			bmhq_pkg::S_RM_HOLD: begin
				e_q   <= rd;
				pos_q <= '0;
			end
			bmhq_pkg::S_DN_LEFT: begin
				c_q <= rd;
			end
			bmhq_pkg::S_DN_CMP: begin
				if (right_gt) begin
					pos_q <= rc_idx[AW-1:0];
				end else if (left_gt) begin
					pos_q <= lc_idx[AW-1:0];
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_tag_q    <= res_tag_q;
			out_occ_q    <= bmhq_pkg::OCC_W'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_occ_q, out_tag_q, out_key_q};
	assign m_axis_tuser  = out_status_q;

endmodule
